>>> hdl/mrat_pkg.sv
// Shared types, constants and the mirror window rules for the region address translator.
// Used by mrat_slot_match and memory_region_address_translator; no dependencies.
`default_nettype none

package mrat_pkg;

  localparam int REGION_SLOTS_DEF = 16;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_B2R  = 2'd1,
    OP_R2B  = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  // Configuration register indexes.
  localparam logic CFG_CONSOLE_KIND = 1'b0;
  localparam logic CFG_REGION_COUNT = 1'b1;

  // Mirror rule sets selected by console_kind.
  localparam logic [2:0] CK_NONE    = 3'd0;
  localparam logic [2:0] CK_MASK_28 = 3'd1;
  localparam logic [2:0] CK_HI_SUB  = 3'd2;
  localparam logic [2:0] CK_LO_SUB  = 3'd3;
  localparam logic [2:0] CK_MASK_21 = 3'd4;
  localparam logic [2:0] CK_MASK_25 = 3'd5;
  localparam logic [2:0] CK_HI2_SUB = 3'd6;

  localparam logic [2:0] KIND_UNKNOWN = 3'd7;
  localparam logic [31:0] ADDR_MISS   = 32'hFFFF_FFFF;

  localparam logic [31:0] W1A_LO = 32'h8C00_0000;
  localparam logic [31:0] W1A_HI = 32'h8CFF_FFFF;
  localparam logic [31:0] W1B_LO = 32'hAC00_0000;
  localparam logic [31:0] W1B_HI = 32'hACFF_FFFF;
  localparam logic [31:0] M1_MASK = 32'h0FFF_FFFF;
  localparam logic [31:0] W2_LO  = 32'hC000_0000;
  localparam logic [31:0] W2_HI  = 32'hC17F_FFFF;
  localparam logic [31:0] HI_OFS = 32'h4000_0000;
  localparam logic [31:0] W3_LO  = 32'h0C00_0000;
  localparam logic [31:0] W3_HI  = 32'h0CFF_FFFF;
  localparam logic [31:0] W3_DST = 32'h0200_0000;
  localparam logic [31:0] W4A_LO = 32'h8000_0000;
  localparam logic [31:0] W4A_HI = 32'h801F_FFFF;
  localparam logic [31:0] W4B_LO = 32'hA000_0000;
  localparam logic [31:0] W4B_HI = 32'hA01F_FFFF;
  localparam logic [31:0] M4_MASK = 32'h001F_FFFF;
  localparam logic [31:0] W5A_LO = 32'h2000_0000;
  localparam logic [31:0] W5A_HI = 32'h21FF_FFFF;
  localparam logic [31:0] W5B_LO = 32'h3010_0000;
  localparam logic [31:0] W5B_HI = 32'h31FF_FFFF;
  localparam logic [31:0] M5_MASK = 32'h01FF_FFFF;
  localparam logic [31:0] W6_LO  = 32'hD000_0000;
  localparam logic [31:0] W6_HI  = 32'hD3FF_FFFF;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] last;
    logic [31:0] real_base;
    logic [31:0] span;      // last - start
    logic        rev;       // last below start, never matches a real query
    logic [2:0]  kind;
  } entry_t;

  typedef struct packed {
    logic byte_hit;
    logic real_hit;
    logic mirr_hit;
  } match_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] addr;
  } mirror_t;

  function automatic logic in_win(input logic [31:0] a, input logic [31:0] lo,
                                  input logic [31:0] hi);
    in_win = (a >= lo) && (a <= hi);
  endfunction

  function automatic mirror_t mirror_map(input logic [2:0] ck, input logic [31:0] a);
    mirror_t m;
    m.ok   = 1'b0;
    m.addr = a;
    case (ck)
      CK_MASK_28: begin
        m.ok   = in_win(a, W1A_LO, W1A_HI) || in_win(a, W1B_LO, W1B_HI);
        m.addr = a & M1_MASK;
      end
      CK_HI_SUB: begin
        m.ok   = in_win(a, W2_LO, W2_HI);
        m.addr = a - HI_OFS;
      end
      CK_LO_SUB: begin
        m.ok   = in_win(a, W3_LO, W3_HI);
        m.addr = a - (W3_LO - W3_DST);
      end
      CK_MASK_21: begin
        m.ok   = in_win(a, W4A_LO, W4A_HI) || in_win(a, W4B_LO, W4B_HI);
        m.addr = a & M4_MASK;
      end
      CK_MASK_25: begin
        m.ok   = in_win(a, W5A_LO, W5A_HI) || in_win(a, W5B_LO, W5B_HI);
        m.addr = a & M5_MASK;
      end
      CK_HI2_SUB: begin
        m.ok   = in_win(a, W2_LO, W2_HI) || in_win(a, W6_LO, W6_HI);
        m.addr = a - HI_OFS;
      end
      default: begin
        m.ok   = 1'b0;
        m.addr = a;
      end
    endcase
    mirror_map = m;
  endfunction

endpackage

`default_nettype wire

>>> hdl/mrat_slot_match.sv
// Range comparators for one region slot: byte window, real window, and real window
// of the mirrored address. Depends on mrat_pkg.
`default_nettype none

module mrat_slot_match
  import mrat_pkg::*;
(
  input  wire logic        slot_on,
  input  wire entry_t      entry,
  input  wire logic [31:0] addr,
  input  wire logic [31:0] mirr_addr,
  output match_t           match
);

  logic [31:0] real_ofs;
  logic [31:0] mirr_ofs;

  assign real_ofs = addr - entry.real_base;
  assign mirr_ofs = mirr_addr - entry.real_base;

  assign match.byte_hit = slot_on && (addr >= entry.start) && (addr <= entry.last);
  assign match.real_hit = slot_on && !entry.rev && (addr >= entry.real_base) &&
                          (real_ofs <= entry.span);
  assign match.mirr_hit = slot_on && !entry.rev && (mirr_addr >= entry.real_base) &&
                          (mirr_ofs <= entry.span);

endmodule

`default_nettype wire

>>> hdl/memory_region_address_translator.sv
// Top level of the region address translator: input register, slot compare stage,
// select stage and output register. Depends on mrat_pkg and mrat_slot_match.
// Accepts one beat per clock while in_stall is low and returns one result beat per input
// beat, in order. Table loads travel the same pipeline and are committed as they leave the
// compare stage; a query directly behind a load sees the new entry through a bypass, so a
// load never holds up the query behind it. The four register stages are mirror mapping,
// parallel slot compare, priority select with table read, and the final add.
`default_nettype none

module memory_region_address_translator
  import mrat_pkg::*;
#(
  parameter int REGION_SLOTS = REGION_SLOTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [4:0]  cfg_wdata,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_operation,
  input  wire logic [31:0] in_query_address,
  input  wire logic [3:0]  in_entry_index,
  input  wire logic [31:0] in_entry_start,
  input  wire logic [31:0] in_entry_end,
  input  wire logic [31:0] in_entry_real_base,
  input  wire logic [2:0]  in_entry_kind,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_result_address,
  output logic             out_hit,
  output logic [3:0]       out_region_index,
  output logic [2:0]       out_region_kind
);

  localparam int SLOT_W = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;

  // Configuration.
  logic [2:0] console_kind_r;
  logic [4:0] region_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      console_kind_r <= CK_NONE;
      region_count_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CONSOLE_KIND: console_kind_r <= cfg_wdata[2:0];
        CFG_REGION_COUNT: region_count_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Pipeline advance.
  logic v1_r, v2_r, v3_r;
  logic en1, en2, en3, en_out;

  assign en_out   = !out_valid || !out_stall;
  assign en3      = !v3_r || en_out;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_stall = !en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1)    v1_r      <= in_valid;
      if (en2)    v2_r      <= v1_r;
      if (en3)    v3_r      <= v2_r;
      if (en_out) out_valid <= v3_r;
    end
  end

  // Stage 1: input register with the mirror address worked out.
  op_t               op1_r;
  logic [31:0]       addr1_r;
  mirror_t           mirr1_r;
  logic              wr1_r;
  logic [SLOT_W-1:0] widx1_r;
  logic [31:0]       start1_r, last1_r, rbase1_r;
  logic [2:0]        kind1_r;

  always_ff @(posedge clk) begin
    if (en1) begin
      op1_r    <= op_t'(in_operation);
      addr1_r  <= in_query_address;
      mirr1_r  <= mirror_map(console_kind_r, in_query_address);
      wr1_r    <= ({28'd0, in_entry_index} < REGION_SLOTS);
      widx1_r  <= SLOT_W'(in_entry_index);
      start1_r <= in_entry_start;
      last1_r  <= in_entry_end;
      rbase1_r <= in_entry_real_base;
      kind1_r  <= in_entry_kind;
    end
  end

  // Region table, written when a load leaves stage 2.
  entry_t tbl_r [REGION_SLOTS];

  op_t               op2_r;
  logic [31:0]       addr2_r;
  mirror_t           mirr2_r;
  logic              wr2_r;
  logic [SLOT_W-1:0] widx2_r;
  entry_t            ent2_r;
  logic [REGION_SLOTS-1:0] byte_v2_r, real_v2_r, mirr_v2_r;

  logic load2;
  assign load2 = v2_r && (op2_r == OP_LOAD) && wr2_r;

  always_ff @(posedge clk) begin
    if (en3 && load2) begin
      tbl_r[widx2_r] <= ent2_r;
    end
  end

  // Stage 2: every slot compared in parallel; a load still in stage 2 is bypassed.
  logic [REGION_SLOTS-1:0] byte_v, real_v, mirr_v;

  for (genvar g = 0; g < REGION_SLOTS; g++) begin : g_slot
    entry_t eff;
    match_t m;
    logic   on;

    assign on  = (32'(g) < 32'(region_count_r));
    assign eff = (load2 && (widx2_r == SLOT_W'(g))) ? ent2_r : tbl_r[g];

    mrat_slot_match u_match (
      .slot_on   (on),
      .entry     (eff),
      .addr      (addr1_r),
      .mirr_addr (mirr1_r.addr),
      .match     (m)
    );

    assign byte_v[g] = m.byte_hit;
    assign real_v[g] = m.real_hit;
    assign mirr_v[g] = m.mirr_hit;
  end

  entry_t ent1;
  always_comb begin
    ent1.start     = start1_r;
    ent1.last      = last1_r;
    ent1.real_base = rbase1_r;
    ent1.span      = last1_r - start1_r;
    ent1.rev       = (last1_r < start1_r);
    ent1.kind      = kind1_r;
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      op2_r     <= op1_r;
      addr2_r   <= addr1_r;
      mirr2_r   <= mirr1_r;
      wr2_r     <= wr1_r;
      widx2_r   <= widx1_r;
      ent2_r    <= ent1;
      byte_v2_r <= byte_v;
      real_v2_r <= real_v;
      mirr_v2_r <= mirr_v;
    end
  end

  // Stage 3: lowest matching slot, then the table read for its operands.
  function automatic logic [SLOT_W-1:0] first_set(input logic [REGION_SLOTS-1:0] v);
    logic [SLOT_W-1:0] idx;
    idx = '0;
    for (int i = REGION_SLOTS - 1; i >= 0; i--) begin
      if (v[i]) idx = SLOT_W'(i);
    end
    first_set = idx;
  endfunction

  logic              hit3_nxt;
  logic              use_rb;
  logic [SLOT_W-1:0] idx3_nxt;
  logic [31:0]       q3_nxt;
  entry_t            sel;

  always_comb begin
    hit3_nxt = 1'b0;
    use_rb   = 1'b0;
    idx3_nxt = '0;
    q3_nxt   = addr2_r;
    case (op2_r)
      OP_B2R: begin
        hit3_nxt = |byte_v2_r;
        idx3_nxt = first_set(byte_v2_r);
      end
      OP_R2B: begin
        use_rb = 1'b1;
        if (|real_v2_r) begin
          hit3_nxt = 1'b1;
          idx3_nxt = first_set(real_v2_r);
        end else if (mirr2_r.ok && |mirr_v2_r) begin
          hit3_nxt = 1'b1;
          idx3_nxt = first_set(mirr_v2_r);
          q3_nxt   = mirr2_r.addr;
        end
      end
      default: ;
    endcase
  end

  assign sel = tbl_r[idx3_nxt];

  logic              hit3_r;
  logic [SLOT_W-1:0] idx3_r;
  logic [31:0]       q3_r, sub3_r, add3_r;
  logic [2:0]        kind3_r;

  always_ff @(posedge clk) begin
    if (en3) begin
      hit3_r  <= hit3_nxt;
      idx3_r  <= idx3_nxt;
      q3_r    <= q3_nxt;
      sub3_r  <= use_rb ? sel.real_base : sel.start;
      add3_r  <= use_rb ? sel.start : sel.real_base;
      kind3_r <= sel.kind;
    end
  end

  // Output register: offset into the region plus the opposite base.
  always_ff @(posedge clk) begin
    if (en_out) begin
      out_hit            <= hit3_r;
      out_result_address <= hit3_r ? (q3_r - sub3_r + add3_r) : ADDR_MISS;
      out_region_index   <= hit3_r ? 4'(idx3_r) : 4'd0;
      out_region_kind    <= hit3_r ? kind3_r : KIND_UNKNOWN;
    end
  end

endmodule

`default_nettype wire
